// ===== sv/nmea_pkg.sv =====
// Shared types, codes and lookup functions for the NMEA sentence parser.
`default_nettype none

package nmea_pkg;

  localparam int MAX_FIELDS_DEFAULT = 32;
  localparam int ID_MAX = 5;
  localparam int ID_TYPES = 11;

  localparam logic [2:0] ID_OVER = 3'd6;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_LF     = 8'h0A;

  localparam logic [2:0] PH_HUNT   = 3'd0;
  localparam logic [2:0] PH_ID     = 3'd1;
  localparam logic [2:0] PH_FIELDS = 3'd2;
  localparam logic [2:0] PH_HEX    = 3'd3;
  localparam logic [2:0] PH_TAIL   = 3'd4;

  localparam logic [1:0] EV_CHAR      = 2'd0;
  localparam logic [1:0] EV_FIELD_END = 2'd1;
  localparam logic [1:0] EV_SENT_END  = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_CKSUM = 3'd1;
  localparam logic [2:0] ST_BAD_HEX  = 3'd2;
  localparam logic [2:0] ST_MISMATCH = 3'd3;
  localparam logic [2:0] ST_NO_COMMA = 3'd4;
  localparam logic [2:0] ST_UNKNOWN  = 3'd5;

  localparam logic [8*ID_MAX-1:0] ID_TABLE [ID_TYPES] = '{
    "GPGSV", "GLGSV", "GAGSV", "GBGSV", "GIGSV",
    "GNGLL", "GNZDA", "GNRMC", "GNVTG", "GNGGA", "GNGSA"
  };

  typedef logic [0:ID_MAX-1][7:0] id_chars_t;

  typedef struct packed {
    logic [2:0] phase;
    logic [7:0] running_xor;
    id_chars_t  id_chars;
    logic [2:0] id_length;
    logic [4:0] field_count;
    logic [3:0] type_code;
    logic [3:0] hex_high;
    logic [1:0] hex_digits_seen;
    logic [2:0] pending_status;
  } parse_state_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [4:0] field_index;
    logic [7:0] char_value;
    logic [3:0] sentence_type;
    logic [2:0] status;
    logic [7:0] computed_checksum;
  } result_t;

  // Bit 4 set means the byte is not a hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) v = {1'b0, c[3:0]};
    else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
      v = {1'b0, c[3:0] + 4'd9};
    return v;
  endfunction

  function automatic logic [3:0] lookup_type(input id_chars_t id, input logic [2:0] len);
    logic [3:0] t;
    t = 4'd0;
    if (len == 3'(ID_MAX)) begin
      for (int i = ID_TYPES - 1; i >= 0; i--) begin
        if (id == ID_TABLE[i]) t = 4'(i + 1);
      end
    end
    return t;
  endfunction

endpackage

`default_nettype wire

// ===== sv/nmea_sentence_parser_top.sv =====
// NMEA 0183 sentence parser: one received byte in, field and sentence events out.
//
// Input channel: in_valid / in_stall carry one rx_byte per transaction.
// Output channel: out_valid / out_stall carry one event per transaction:
// a field character, an end of field (with its index), or an end of sentence
// at line feed with sentence type, status and computed checksum.
// A byte produces zero or one events. Accepts one byte per cycle while in_stall
// is low; each event is registered in the output buffer when its byte is taken.
// The output register is backed by a one-entry skid register, so a byte is
// still taken while an event waits; in_stall rises only when both hold an
// event, and falls at the edge at which the receiver takes one.
// Reset (synchronous, rst high) empties both registers and returns the parser
// to hunting for a dollar sign; bytes before it produce nothing.
// Fields of a sentence come out before its status is known; discard them
// unless the end-of-sentence event reports status ok.
`default_nettype none

module nmea_sentence_parser_top #(
  parameter int MAX_FIELDS = nmea_pkg::MAX_FIELDS_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      event_kind,
  output logic [4:0]      field_index,
  output logic [7:0]      char_value,
  output logic [3:0]      sentence_type,
  output logic [2:0]      status,
  output logic [7:0]      computed_checksum
);

  logic              take;
  logic              res_valid;
  nmea_pkg::result_t res;
  nmea_pkg::result_t dout;

  assign take = in_valid && !in_stall;

  nmea_core #(.MAX_FIELDS(MAX_FIELDS)) u_core (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .rx_byte   (rx_byte),
    .res       (res),
    .res_valid (res_valid)
  );

  nmea_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (take && res_valid),
    .din       (res),
    .out_stall (out_stall),
    .full      (in_stall),
    .out_valid (out_valid),
    .dout      (dout)
  );

  assign event_kind        = dout.event_kind;
  assign field_index       = dout.field_index;
  assign char_value        = dout.char_value;
  assign sentence_type     = dout.sentence_type;
  assign status            = dout.status;
  assign computed_checksum = dout.computed_checksum;

endmodule

`default_nettype wire

// ===== sv/nmea_core.sv =====
// Sentence state register and the per-byte next-state and event logic.
`default_nettype none

module nmea_core #(
  parameter int MAX_FIELDS = nmea_pkg::MAX_FIELDS_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             take,
  input  wire logic [7:0]       rx_byte,
  output nmea_pkg::result_t     res,
  output logic                  res_valid
);

  localparam int FieldLastInt = (MAX_FIELDS - 1 > 31) ? 31 : MAX_FIELDS - 1;
  localparam logic [4:0] FIELD_LAST = 5'(FieldLastInt);

  nmea_pkg::parse_state_t st;
  nmea_pkg::parse_state_t st_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (take) begin
      st <= st_next;
    end
  end

  always_comb begin
    logic [4:0] hv;
    logic [7:0] expected;
    logic [2:0] st_code;
    st_next   = st;
    res       = '0;
    res_valid = 1'b0;
    hv        = nmea_pkg::hex_value(rx_byte);
    expected  = {st.hex_high, hv[3:0]};
    st_code   = nmea_pkg::ST_NO_CKSUM;

    if (st.phase == nmea_pkg::PH_HUNT) begin
      if (rx_byte == nmea_pkg::CH_DOLLAR) begin
        st_next       = '0;
        st_next.phase = nmea_pkg::PH_ID;
      end
    end else if (rx_byte == nmea_pkg::CH_LF) begin
      if (st.phase == nmea_pkg::PH_HEX) begin
        st_code = (st.hex_digits_seen == 2'd0) ? nmea_pkg::ST_NO_CKSUM
                                                : nmea_pkg::ST_BAD_HEX;
      end else if (st.phase == nmea_pkg::PH_TAIL) begin
        st_code = st.pending_status;
        if (st_code == nmea_pkg::ST_OK && st.type_code == 4'd0)
          st_code = nmea_pkg::ST_UNKNOWN;
      end
      res_valid             = 1'b1;
      res.event_kind        = nmea_pkg::EV_SENT_END;
      res.sentence_type     = st.type_code;
      res.status            = st_code;
      res.computed_checksum = st.running_xor;
      st_next               = '0;
    end else begin
      unique case (st.phase)
        nmea_pkg::PH_ID: begin
          if (rx_byte == nmea_pkg::CH_STAR) begin
            st_next.pending_status = nmea_pkg::ST_NO_COMMA;
            st_next.phase          = nmea_pkg::PH_HEX;
          end else begin
            st_next.running_xor = st.running_xor ^ rx_byte;
            if (rx_byte == nmea_pkg::CH_COMMA) begin
              st_next.type_code   = nmea_pkg::lookup_type(st.id_chars, st.id_length);
              st_next.field_count = 5'd0;
              st_next.phase       = nmea_pkg::PH_FIELDS;
            end else if (st.id_length < 3'(nmea_pkg::ID_MAX)) begin
              st_next.id_chars[st.id_length] = rx_byte;
              st_next.id_length              = st.id_length + 3'd1;
            end else begin
              st_next.id_length = nmea_pkg::ID_OVER;
            end
          end
        end
        nmea_pkg::PH_FIELDS: begin
          res_valid       = 1'b1;
          res.field_index = st.field_count;
          if (rx_byte == nmea_pkg::CH_STAR) begin
            st_next.phase  = nmea_pkg::PH_HEX;
            res.event_kind = nmea_pkg::EV_FIELD_END;
          end else begin
            st_next.running_xor = st.running_xor ^ rx_byte;
            if (rx_byte == nmea_pkg::CH_COMMA) begin
              // saturate the index at the last field
              if (st.field_count < FIELD_LAST)
                st_next.field_count = st.field_count + 5'd1;
              res.event_kind = nmea_pkg::EV_FIELD_END;
            end else begin
              res.event_kind = nmea_pkg::EV_CHAR;
              res.char_value = rx_byte;
            end
          end
        end
        nmea_pkg::PH_HEX: begin
          if (st.hex_digits_seen == 2'd0) begin
            if (hv[4]) begin
              st_next.pending_status = nmea_pkg::ST_BAD_HEX;
              st_next.hex_high       = 4'd0;
            end else begin
              st_next.hex_high = hv[3:0];
            end
            st_next.hex_digits_seen = 2'd1;
          end else begin
            if (hv[4]) begin
              st_next.pending_status = nmea_pkg::ST_BAD_HEX;
            end else if (st.pending_status != nmea_pkg::ST_BAD_HEX &&
                         expected != st.running_xor) begin
              st_next.pending_status = nmea_pkg::ST_MISMATCH;
            end
            st_next.hex_digits_seen = 2'd2;
            st_next.phase           = nmea_pkg::PH_TAIL;
          end
        end
        default: begin
          // hold in the tail until line feed; drop any unused phase code
          if (st.phase != nmea_pkg::PH_TAIL) st_next = '0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/nmea_out_buf.sv =====
// Output register with one skid entry between the parser and the receiver.
`default_nettype none

module nmea_out_buf (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire nmea_pkg::result_t din,
  input  wire logic              out_stall,
  output logic                   full,
  output logic                   out_valid,
  output nmea_pkg::result_t      dout
);

  logic              skid_valid;
  nmea_pkg::result_t skid;

  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (push) begin
      if (out_valid && out_stall) skid_valid <= 1'b1;
      else out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      if (skid_valid) skid_valid <= 1'b0;
      else out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (out_valid && out_stall) skid <= din;
      else dout <= din;
    end else if (out_valid && !out_stall && skid_valid) begin
      dout <= skid;
    end
  end

endmodule

`default_nettype wire

// ===== sv/nmea_checker.sv =====
// Port-level checks for the NMEA sentence parser, bound to the top level.
`default_nettype none

module nmea_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic [7:0] rx_byte,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] event_kind,
  input wire logic [4:0] field_index,
  input wire logic [7:0] char_value,
  input wire logic [3:0] sentence_type,
  input wire logic [2:0] status,
  input wire logic [7:0] computed_checksum
);

  // input stalls only while a result is already waiting on the output
  a_stall_needs_out: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("in_stall high with no pending output");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(event_kind) &&
      $stable(field_index) && $stable(char_value) && $stable(sentence_type) &&
      $stable(status) && $stable(computed_checksum))
    else $error("stalled output transaction changed");

  a_end_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind == nmea_pkg::EV_SENT_END |->
      field_index == 5'd0 && char_value == 8'd0)
    else $error("end of sentence carries field data");

  a_field_zeros: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind != nmea_pkg::EV_SENT_END |->
      sentence_type == 4'd0 && status == nmea_pkg::ST_OK && computed_checksum == 8'd0)
    else $error("field event carries sentence data");

  a_char_not_delim: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind == nmea_pkg::EV_CHAR |->
      char_value != nmea_pkg::CH_COMMA && char_value != nmea_pkg::CH_STAR &&
      char_value != nmea_pkg::CH_LF)
    else $error("delimiter emitted as field character");

endmodule

bind nmea_sentence_parser_top nmea_checker u_nmea_checker (.*);

`default_nettype wire
